>>> rtl/rrp_pkg.sv
// ---------------------------------------------------------------------------
// rrp_pkg: shared definitions for the RISC-V relocation patcher
// Relocation type numbers, write kinds, status codes, FSM state and the
// command/status structs between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

  // default depth of the HI20/LO12 pairing table
  localparam int PAIR_ENTRIES_DEF = 16;

  // psABI relocation type numbers
  localparam logic [7:0] TY_64           = 8'd2;
  localparam logic [7:0] TY_BRANCH       = 8'd16;
  localparam logic [7:0] TY_CALL         = 8'd18;
  localparam logic [7:0] TY_PCREL_HI20   = 8'd23;
  localparam logic [7:0] TY_PCREL_LO12_I = 8'd24;
  localparam logic [7:0] TY_PCREL_LO12_S = 8'd25;
  localparam logic [7:0] TY_ADD32        = 8'd35;
  localparam logic [7:0] TY_SUB32        = 8'd39;
  localparam logic [7:0] TY_RVC_BRANCH   = 8'd44;
  localparam logic [7:0] TY_RVC_JUMP     = 8'd45;
  localparam logic [7:0] TY_RELAX        = 8'd51;

  // write kinds
  localparam logic [2:0] WK_NONE  = 3'd0;
  localparam logic [2:0] WK_HALF  = 3'd1;
  localparam logic [2:0] WK_WORD  = 3'd2;
  localparam logic [2:0] WK_TWO   = 3'd3;
  localparam logic [2:0] WK_DWORD = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_OFF,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UPDATE,
    S_DONE
  } rrp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic sum;      // V = S + A
    logic offs;     // off = V - P, start a table scan
    logic read;     // read the table entry under the scan index
    logic compare;  // compare it, step the scan index
    logic update;   // write the HI20 entry
    logic emit;     // load the result register
  } rrp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_hi;     // item is PCREL_HI20
    logic is_lo;     // item is PCREL_LO12_I or _S
    logic hit;       // entry under compare matches the key
    logic scan_last; // scan index is at the last entry
    logic out_free;  // result register can take an item
  } rrp_stat_t;

endpackage

`default_nettype wire

>>> rtl/rrp_ctrl.sv
// ---------------------------------------------------------------------------
// rrp_ctrl: sequencing controller
// Walks each item through sum, offset, table scan (HI20/LO12 only), table update (HI20 only) and result.
// ---------------------------------------------------------------------------
`default_nettype none

module rrp_ctrl
  import rrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire rrp_stat_t stat,
  output rrp_cmd_t       cmd
);

  rrp_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SUM;
      end
      S_SUM: state_nxt = S_OFF;
      S_OFF: begin
        if (stat.is_hi || stat.is_lo) state_nxt = S_SCAN_RD;
        else state_nxt = S_DONE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.hit || stat.scan_last) begin
          state_nxt = stat.is_hi ? S_UPDATE : S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_UPDATE: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs; no item is taken while reset is held
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        cmd.load  = in_tvalid && rst_n;
      end
      S_SUM:      cmd.sum     = 1'b1;
      S_OFF:      cmd.offs    = 1'b1;
      S_SCAN_RD:  cmd.read    = 1'b1;
      S_SCAN_CMP: cmd.compare = 1'b1;
      S_UPDATE:   cmd.update  = 1'b1;
      S_DONE:     cmd.emit    = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rrp_dpath.sv
// ---------------------------------------------------------------------------
// rrp_dpath: relocation datapath
// Offset arithmetic, pairing table memory with sequential lookup, the
// instruction field patching and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rrp_dpath
  import rrp_pkg::*;
#(
  parameter int PAIR_ENTRIES = PAIR_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrp_cmd_t           cmd,
  output rrp_stat_t               stat,
  input  wire logic               section_start,
  input  wire logic [7:0]         reloc_type,
  input  wire logic [63:0]        patch_address,
  input  wire logic [63:0]        symbol_value,
  input  wire logic signed [63:0] addend,
  input  wire logic [31:0]        old_word_first,
  input  wire logic [31:0]        old_word_second,
  input  wire logic               out_tready,
  output logic                    out_valid,
  output logic [31:0]             new_word_first,
  output logic [31:0]             new_word_second,
  output logic [2:0]              write_kind,
  output logic [1:0]              status
);

  localparam int IDX_W = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAIR_ENTRIES - 1);

  // captured item
  logic [7:0]         type_r;
  logic [63:0]        p_r, s_r;
  logic signed [63:0] a_r;
  logic [31:0]        w0_r, w1_r;
  logic [63:0]        v_r, off_r;

  // pairing table
  logic [63:0]             loc_mem [PAIR_ENTRIES];
  logic [11:0]             low_mem [PAIR_ENTRIES];
  logic [PAIR_ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]        next_slot_r;

  // scan state
  logic [IDX_W-1:0] scan_idx_r;
  logic [63:0]      rd_loc_r;
  logic [11:0]      rd_low_r;
  logic             rd_valid_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [11:0]      found_lo_r;

  // result register
  logic        out_valid_r;
  logic [31:0] n0_r, n1_r;
  logic [2:0]  kind_r;
  logic [1:0]  st_r;

  logic        is_hi, is_lo, hit;
  logic [63:0] key;
  logic [IDX_W-1:0] wr_slot;

  assign is_hi = (type_r == TY_PCREL_HI20);
  assign is_lo = (type_r == TY_PCREL_LO12_I) || (type_r == TY_PCREL_LO12_S);
  assign key   = is_hi ? p_r : s_r;
  assign hit   = rd_valid_r && (rd_loc_r == key);
  assign wr_slot = found_r ? found_idx_r : next_slot_r;

  assign stat.is_hi     = is_hi;
  assign stat.is_lo     = is_lo;
  assign stat.hit       = hit;
  assign stat.scan_last = (scan_idx_r == IDX_LAST);
  assign stat.out_free  = !out_valid_r || out_tready;

  // item capture and offset arithmetic, one wide add per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= reloc_type;
      p_r    <= patch_address;
      s_r    <= symbol_value;
      a_r    <= addend;
      w0_r   <= old_word_first;
      w1_r   <= old_word_second;
    end
    if (cmd.sum)  v_r   <= s_r + $unsigned(a_r);
    if (cmd.offs) off_r <= v_r - p_r;
  end

  // table control: valid bits and round-robin slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_slot_r <= '0;
    end else if (cmd.load && section_start) begin
      valid_r     <= '0;
      next_slot_r <= '0;
    end else if (cmd.update) begin
      valid_r[wr_slot] <= 1'b1;
      if (!found_r) begin
        next_slot_r <= (next_slot_r == IDX_LAST) ? '0 : next_slot_r + 1'b1;
      end
    end
  end

  // table memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      loc_mem[wr_slot] <= p_r;
      low_mem[wr_slot] <= off_r[11:0];
    end
    if (cmd.read) begin
      rd_loc_r   <= loc_mem[scan_idx_r];
      rd_low_r   <= low_mem[scan_idx_r];
      rd_valid_r <= valid_r[scan_idx_r];
    end
  end

  // scan index and match capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.offs) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.compare) begin
      if (hit) begin
        found_r     <= 1'b1;
        found_idx_r <= scan_idx_r;
        found_lo_r  <= rd_low_r;
      end else if (scan_idx_r != IDX_LAST) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // field patching
  logic [31:0] o, lo, l, hi_part, h, n0, n1;
  logic [2:0]  kind;
  logic [1:0]  st;

  always_comb begin
    o       = off_r[31:0];
    lo      = {20'd0, off_r[11:0]};
    l       = {20'd0, found_lo_r};
    hi_part = (o + 32'h800) & 32'hfffff000;
    h       = '0;
    n0      = w0_r;
    n1      = w1_r;
    kind    = WK_NONE;
    st      = ST_OK;
    unique case (type_r)
      TY_64: begin
        n0   = v_r[31:0];
        n1   = v_r[63:32];
        kind = WK_DWORD;
      end
      TY_PCREL_HI20: begin
        n0   = (w0_r & 32'hfff) | hi_part;
        kind = WK_WORD;
      end
      TY_CALL: begin
        n0   = (w0_r & 32'hfff) | hi_part;
        n1   = (w1_r & 32'hfffff) | (lo << 20);
        kind = WK_TWO;
      end
      TY_BRANCH: begin
        n0 = (w0_r & 32'h1fff07f) | ((o & 32'h1000) << 19) | ((o & 32'h800) >> 4)
           | ((o & 32'h7e0) << 20) | ((o & 32'h1e) << 7);
        kind = WK_WORD;
      end
      TY_RVC_JUMP: begin
        h = (w0_r & 32'he003) | ((o & 32'h800) << 1) | ((o & 32'h400) >> 2)
          | ((o & 32'h300) << 1) | ((o & 32'h80) >> 1) | ((o & 32'h40) << 1)
          | ((o & 32'h20) >> 3) | ((o & 32'h10) << 7) | ((o & 32'he) << 2);
        n0   = {w0_r[31:16], h[15:0]};
        kind = WK_HALF;
      end
      TY_RVC_BRANCH: begin
        h = (w0_r & 32'he383) | ((o & 32'h100) << 4) | ((o & 32'hc0) >> 1)
          | ((o & 32'h20) >> 3) | ((o & 32'h18) << 7) | ((o & 32'h6) << 2);
        n0   = {w0_r[31:16], h[15:0]};
        kind = WK_HALF;
      end
      TY_RELAX: ;
      TY_ADD32: begin
        n0   = w0_r + v_r[31:0];
        kind = WK_WORD;
      end
      TY_SUB32: begin
        n0   = w0_r - v_r[31:0];
        kind = WK_WORD;
      end
      TY_PCREL_LO12_I: begin
        if (found_r) begin
          n0   = (w0_r & 32'hfffff) | (l << 20);
          kind = WK_WORD;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      TY_PCREL_LO12_S: begin
        if (found_r) begin
          n0   = (w0_r & 32'h1fff07f) | ((l & 32'hfe0) << 20) | ((l & 32'h1f) << 7);
          kind = WK_WORD;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      default: st = ST_UNKNOWN;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      n0_r   <= n0;
      n1_r   <= n1;
      kind_r <= kind;
      st_r   <= st;
    end
  end

  assign out_valid       = out_valid_r;
  assign new_word_first  = n0_r;
  assign new_word_second = n1_r;
  assign write_kind      = kind_r;
  assign status          = st_r;

endmodule

`default_nettype wire

>>> rtl/riscv_relocation_patcher_core.sv
// ---------------------------------------------------------------------------
// riscv_relocation_patcher_core: RISC-V RELA relocation patcher
// Patches instruction and data words for one relocation per item and pairs
// PCREL_LO12 items with earlier PCREL_HI20 items through a small table.
// ---------------------------------------------------------------------------
// One relocation goes in, one result comes out. Items are handled one at a
// time: a type that does not use the pairing table goes from accept to the
// next accept through capture, S+A, V-P and result, and the result step
// waits until the output register is free. PCREL_HI20 and PCREL_LO12 items
// scan the pairing memory one entry at a time (read, compare), stopping at
// the match or the last entry, so they look at up to PAIR_ENTRIES entries;
// a PCREL_HI20 then adds a table write. A result waits in the output register
// while the block takes the next item. section_start on an item clears the
// table valid bits in the cycle it is accepted; there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module riscv_relocation_patcher_core
  import rrp_pkg::*;
#(
  parameter int PAIR_ENTRIES = PAIR_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [63:0] patch_address, [127:64] symbol_value, [191:128] addend,
  // [223:192] old_word_first, [255:224] old_word_second
  input  wire logic [255:0] in_tdata,
  // [0] section_start, [8:1] reloc_type
  input  wire logic [8:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] new_word_first, [63:32] new_word_second
  output logic [63:0]       out_tdata,
  // [2:0] write_kind, [4:3] status
  output logic [4:0]        out_tuser
);

  rrp_cmd_t  cmd;
  rrp_stat_t stat;

  logic [31:0] new_word_first, new_word_second;
  logic [2:0]  write_kind;
  logic [1:0]  status;

  rrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrp_dpath #(
    .PAIR_ENTRIES (PAIR_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .section_start   (in_tuser[0]),
    .reloc_type      (in_tuser[8:1]),
    .patch_address   (in_tdata[63:0]),
    .symbol_value    (in_tdata[127:64]),
    .addend          ($signed(in_tdata[191:128])),
    .old_word_first  (in_tdata[223:192]),
    .old_word_second (in_tdata[255:224]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .new_word_first  (new_word_first),
    .new_word_second (new_word_second),
    .write_kind      (write_kind),
    .status          (status)
  );

  assign out_tdata = {new_word_second, new_word_first};
  assign out_tuser = {status, write_kind};

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is in work");

  // a fresh result is only produced from a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an item in work");

  // an error status never comes with a write
  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[4:3] != ST_OK) |-> out_tuser[2:0] == WK_NONE)
    else $error("error status with nonzero write kind");

endmodule

`default_nettype wire

>>> tb/sv/riscv_relocation_patcher_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// riscv_relocation_patcher_core_test: self-checking bench for the patcher
// Walks a short directed table of relocations, then random sections built
// mostly from HI20/LO12 pairs over a small address pool. Each accepted item
// is run through a local patch predictor with its own copy of the pairing
// table; results are checked in order against predicted or directed patches.
// ---------------------------------------------------------------------------
module riscv_relocation_patcher_core_test;
  import rrp_pkg::*;

  localparam int RANDOM_ITEMS     = 2000;
  localparam int RX_HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES     = 100;
  localparam int WATCHDOG_CYCLES  = 4000;
  localparam int MAX_REPORTS      = 10;
  localparam int MAX_SITES        = 24;
  localparam logic [63:0] SITE_A = 64'h0000_0000_8000_1000;

  // one relocation as it enters the block
  typedef struct packed {
    logic        section_start;
    logic [7:0]  rtype;
    logic [63:0] paddr;
    logic [63:0] sym;
    logic [63:0] addend;
    logic [31:0] w0;
    logic [31:0] w1;
  } reloc_t;

  // one patch as it leaves the block
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [2:0]  kind;
    logic [1:0]  status;
  } patch_t;

  typedef struct {
    patch_t     want;
    logic [7:0] rtype;
    int         seq;
  } pending_patch_t;

  typedef struct {
    reloc_t r;
    bit     typed;
    patch_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [8:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [4:0]   out_tuser;

  // local copy of the HI20 pairing table
  logic [63:0] hi_loc [PAIR_ENTRIES_DEF];
  logic [11:0] hi_lo12 [PAIR_ENTRIES_DEF];
  bit          hi_valid [PAIR_ENTRIES_DEF];
  int          hi_next = 0;

  pending_patch_t expected_patches [$];
  dir_row_t       dir_table [$];

  // address pool for the current random section
  logic [63:0] hi_sites [MAX_SITES];
  int          site_cnt;

  int  sent_cnt = 0, results_seen = 0, fail_cnt = 0, section_cnt = 0;
  int  lo_hit_cnt = 0, lo_miss_cnt = 0, hi_cnt = 0, unknown_cnt = 0;
  int  rx_stall = 0, idle_cycles = 0;
  bit  steady = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

  riscv_relocation_patcher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small signed value, sign-extended to 64 bits
  function automatic logic [63:0] rand_near();
    logic [31:0] x;
    x = $urandom;
    return {{44{x[19]}}, x[19:0]};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    else if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int find_site(input logic [63:0] addr);
    for (int k = 0; k < PAIR_ENTRIES_DEF; k++)
      if (hi_valid[k] && hi_loc[k] == addr) return k;
    return -1;
  endfunction

  // predicted patch for one relocation; updates the pairing table
  function automatic patch_t patch_relocation(input reloc_t r);
    logic [63:0] v, off;
    logic [31:0] o, hi;
    logic [15:0] h;
    logic [11:0] lo, l;
    int k, slot;
    patch_t p;
    v = r.sym + r.addend;
    off = v - r.paddr;
    o = off[31:0];
    hi = o + 32'h800;
    lo = o[11:0];
    p.w0 = r.w0;
    p.w1 = r.w1;
    p.kind = WK_NONE;
    p.status = ST_OK;
    if (r.section_start) begin
      for (k = 0; k < PAIR_ENTRIES_DEF; k++) hi_valid[k] = 1'b0;
      hi_next = 0;
    end
    case (r.rtype)
      TY_64: begin
        p.w0 = v[31:0];
        p.w1 = v[63:32];
        p.kind = WK_DWORD;
      end
      TY_PCREL_HI20: begin
        k = find_site(r.paddr);
        if (k < 0) begin
          slot = hi_next;
          hi_next = (slot + 1) % PAIR_ENTRIES_DEF;
        end else begin
          slot = k;
        end
        hi_loc[slot] = r.paddr;
        hi_lo12[slot] = lo;
        hi_valid[slot] = 1'b1;
        p.w0 = {hi[31:12], r.w0[11:0]};
        p.kind = WK_WORD;
        hi_cnt++;
      end
      TY_CALL: begin
        p.w0 = {hi[31:12], r.w0[11:0]};
        p.w1 = {lo, r.w1[19:0]};
        p.kind = WK_TWO;
      end
      TY_BRANCH: begin
        p.w0 = {o[12], o[10:5], r.w0[24:12], o[4:1], o[11], r.w0[6:0]};
        p.kind = WK_WORD;
      end
      TY_RVC_JUMP: begin
        h = {r.w0[15:13], o[11], o[4], o[9:8], o[10], o[6], o[7], o[3:1], o[5],
             r.w0[1:0]};
        p.w0 = {r.w0[31:16], h};
        p.kind = WK_HALF;
      end
      TY_RVC_BRANCH: begin
        h = {r.w0[15:13], o[8], o[4:3], r.w0[9:7], o[7:6], o[2:1], o[5], r.w0[1:0]};
        p.w0 = {r.w0[31:16], h};
        p.kind = WK_HALF;
      end
      TY_RELAX: ;
      TY_ADD32: begin
        p.w0 = r.w0 + v[31:0];
        p.kind = WK_WORD;
      end
      TY_SUB32: begin
        p.w0 = r.w0 - v[31:0];
        p.kind = WK_WORD;
      end
      TY_PCREL_LO12_I, TY_PCREL_LO12_S: begin
        k = find_site(r.sym);
        if (k < 0) begin
          p.status = ST_NOT_FOUND;
          lo_miss_cnt++;
        end else begin
          l = hi_lo12[k];
          if (r.rtype == TY_PCREL_LO12_I) p.w0 = {l, r.w0[19:0]};
          else p.w0 = {l[11:5], r.w0[24:12], l[4:0], r.w0[6:0]};
          p.kind = WK_WORD;
          lo_hit_cnt++;
        end
      end
      default: begin
        p.status = ST_UNKNOWN;
        unknown_cnt++;
      end
    endcase
    return p;
  endfunction

  function automatic dir_row_t dir_row(input bit ss, input logic [7:0] ty,
                                       input logic [63:0] pa, input logic [63:0] sv,
                                       input logic [63:0] ad, input logic [31:0] w0,
                                       input logic [31:0] w1, input bit typed,
                                       input logic [31:0] ew0, input logic [31:0] ew1,
                                       input logic [2:0] ek, input logic [1:0] est);
    dir_row_t d;
    d.r = '{section_start: ss, rtype: ty, paddr: pa, sym: sv, addend: ad, w0: w0, w1: w1};
    d.typed = typed;
    d.want = '{w0: ew0, w1: ew1, kind: ek, status: est};
    return d;
  endfunction

  // offer one item, hold it until accepted, then queue its patch
  task automatic send_reloc(input reloc_t r, input bit typed, input patch_t want);
    patch_t pred;
    pending_patch_t e;
    int gap;
    in_tdata <= {r.w1, r.w0, r.addend, r.sym, r.paddr};
    in_tuser <= {r.rtype, r.section_start};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = patch_relocation(r);
    e.want = typed ? want : pred;
    e.rtype = r.rtype;
    e.seq = sent_cnt;
    expected_patches.push_back(e);
    sent_cnt++;
    gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let the block drain completely before going on
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_patches.size() != 0);
  endtask

  // new section: fresh address pool, some pools larger than the table
  task automatic open_section();
    site_cnt = $urandom_range(1, MAX_SITES);
    for (int k = 0; k < site_cnt; k++)
      hi_sites[k] = ($urandom_range(0, 2) == 0) ? {32'h0, $urandom & 32'hffff_fffc}
                                                : rand64();
  endtask

  task automatic make_reloc(input bit first, output reloc_t r);
    int roll;
    roll = $urandom_range(0, 99);
    r.section_start = first || ($urandom_range(0, 49) == 0);
    r.w0 = $urandom;
    r.w1 = $urandom;
    r.addend = ($urandom_range(0, 1) == 0) ? rand_near() : rand64();
    if (roll < 35) begin
      r.rtype = TY_PCREL_HI20;
      r.paddr = hi_sites[$urandom_range(0, site_cnt - 1)];
      r.sym = r.paddr + rand_near();
    end else if (roll < 65) begin
      r.rtype = ($urandom_range(0, 1) == 0) ? TY_PCREL_LO12_I : TY_PCREL_LO12_S;
      r.paddr = rand64();
      r.sym = ($urandom_range(0, 9) == 0) ? rand64()
                                          : hi_sites[$urandom_range(0, site_cnt - 1)];
    end else begin
      if (roll < 93) begin
        case ($urandom_range(0, 7))
          0: r.rtype = TY_64;
          1: r.rtype = TY_BRANCH;
          2: r.rtype = TY_CALL;
          3: r.rtype = TY_RVC_BRANCH;
          4: r.rtype = TY_RVC_JUMP;
          5: r.rtype = TY_RELAX;
          6: r.rtype = TY_ADD32;
          default: r.rtype = TY_SUB32;
        endcase
      end else begin
        r.rtype = 8'($urandom_range(0, 255));
      end
      r.paddr = rand64();
      r.sym = ($urandom_range(0, 1) == 0) ? r.paddr + rand_near() : rand64();
    end
  endtask

  // stimulus
  initial begin
    reloc_t r;
    int sec_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: extremes, every type, pairing corner cases
    dir_table.push_back(dir_row(0, TY_64, 64'h0, '1, 64'h0, 32'h1234_5678, 32'h9abc_def0,
                                1, 32'hffff_ffff, 32'hffff_ffff, WK_DWORD, ST_OK));
    dir_table.push_back(dir_row(0, TY_64, '1, 64'h0, 64'h8000_0000_0000_0000, 32'h0, 32'h0,
                                1, 32'h0, 32'h8000_0000, WK_DWORD, ST_OK));
    dir_table.push_back(dir_row(0, 8'd0, SITE_A, SITE_A, 64'h0, 32'h0, 32'hffff_ffff,
                                1, 32'h0, 32'hffff_ffff, WK_NONE, ST_UNKNOWN));
    dir_table.push_back(dir_row(0, 8'd255, SITE_A, SITE_A, 64'h0, 32'hffff_ffff, 32'h0,
                                1, 32'hffff_ffff, 32'h0, WK_NONE, ST_UNKNOWN));
    dir_table.push_back(dir_row(0, TY_RELAX, SITE_A, SITE_A, 64'h4, 32'h13, 32'h13,
                                1, 32'h13, 32'h13, WK_NONE, ST_OK));
    // lookups into an empty table
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_I, 64'h0, SITE_A, 64'h0, 32'h0005_0513,
                                32'h1, 1, 32'h0005_0513, 32'h1, WK_NONE, ST_NOT_FOUND));
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_S, 64'h0, SITE_A, 64'h0, 32'h00a5_2023,
                                32'h2, 1, 32'h00a5_2023, 32'h2, WK_NONE, ST_NOT_FOUND));
    // data relocations wrapping at 32 bits
    dir_table.push_back(dir_row(0, TY_ADD32, 64'h0, 64'h1, 64'h0, 32'hffff_ffff, 32'h5,
                                1, 32'h0, 32'h5, WK_WORD, ST_OK));
    dir_table.push_back(dir_row(0, TY_SUB32, 64'h0, 64'h0, 64'h7fff_ffff_ffff_ffff, 32'h0,
                                32'h6, 1, 32'h1, 32'h6, WK_WORD, ST_OK));
    // branch, call and jump immediates; the compressed forms at both ends of their range
    dir_table.push_back(dir_row(0, TY_BRANCH, SITE_A, SITE_A, 64'hffff_ffff_ffff_fffe,
                                32'h63, 32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_BRANCH, SITE_A, SITE_A, 64'hffe, 32'hffff_ffff,
                                32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_CALL, SITE_A, SITE_A + 64'h1234_5000, 64'h7ff,
                                32'h97, 32'h80e7, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_RVC_JUMP, SITE_A, SITE_A, 64'hffff_ffff_ffff_f800,
                                32'hffff_a001, 32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_RVC_JUMP, SITE_A, SITE_A, 64'h7fe, 32'h0000_a001,
                                32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_RVC_BRANCH, SITE_A, SITE_A, 64'hffff_ffff_ffff_ff00,
                                32'hffff_c001, 32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_RVC_BRANCH, SITE_A, SITE_A, 64'hfe, 32'h0000_c001,
                                32'h0, 0, '0, '0, '0, '0));
    // HI20 then both LO12 forms, then the same address again
    dir_table.push_back(dir_row(0, TY_PCREL_HI20, SITE_A, SITE_A + 64'h2000, 64'h7ff,
                                32'h517, 32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_I, 64'h0, SITE_A, 64'h0, 32'h0005_0513,
                                32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_S, 64'h0, SITE_A, 64'h0, 32'hfea5_2fa3,
                                32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_PCREL_HI20, SITE_A, SITE_A, 64'h800, 32'h517,
                                32'h0, 0, '0, '0, '0, '0));
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_I, 64'h0, SITE_A, 64'h0, 32'hffff_ffff,
                                32'h0, 0, '0, '0, '0, '0));
    // LO12 whose HI20 comes later
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_I, 64'h0, SITE_A + 64'h8, 64'h0, 32'h513,
                                32'h7, 1, 32'h513, 32'h7, WK_NONE, ST_NOT_FOUND));
    dir_table.push_back(dir_row(0, TY_PCREL_HI20, SITE_A + 64'h8, 64'h0, 64'h0, 32'h517,
                                32'h0, 0, '0, '0, '0, '0));
    // section start wipes the table
    dir_table.push_back(dir_row(1, TY_RELAX, SITE_A, SITE_A, 64'h0, 32'h13, 32'h13,
                                1, 32'h13, 32'h13, WK_NONE, ST_OK));
    dir_table.push_back(dir_row(0, TY_PCREL_LO12_S, 64'h0, SITE_A, 64'h0, 32'h00a5_2023,
                                32'h8, 1, 32'h00a5_2023, 32'h8, WK_NONE, ST_NOT_FOUND));

    foreach (dir_table[i]) send_reloc(dir_table[i].r, dir_table[i].typed, dir_table[i].want);
    drain_results();

    // random sections, mostly well-formed HI20/LO12 traffic
    while (sent_cnt < dir_table.size() + RANDOM_ITEMS) begin
      open_section();
      sec_len = $urandom_range(1, 60);
      steady = ($urandom_range(0, 4) == 0);
      if (section_cnt == 3) begin
        // back-to-back items while the result side holds off
        steady = 1'b1;
        hold_req = 1'b1;
        sec_len = 60;
      end
      if (section_cnt == 12) drain_results();
      for (int k = 0; k < sec_len; k++) begin
        make_reloc(k == 0, r);
        send_reloc(r, 1'b0, '0);
      end
      section_cnt++;
    end

    steady = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d relocations in %0d random sections; %0d results checked.",
             sent_cnt, section_cnt, results_seen);
    $display("HI20 writes %0d, LO12 matched %0d / unmatched %0d, unknown types %0d.",
             hi_cnt, lo_hit_cnt, lo_miss_cnt, unknown_cnt);
    if (fail_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check each accepted item, then pick the next ready value
  always @(posedge clk) begin : result_side
    pending_patch_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_patches.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: data %h user %h",
                   $realtime, out_tdata, out_tuser);
      end else begin
        e = expected_patches.pop_front();
        if (out_tdata[31:0] !== e.want.w0 || out_tdata[63:32] !== e.want.w1 ||
            out_tuser[2:0] !== e.want.kind || out_tuser[4:3] !== e.want.status) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] item %0d ty %0d: exp %h %h k%0d s%0d, got %h %h k%0d s%0d",
                     $realtime, e.seq, e.rtype, e.want.w0, e.want.w1, e.want.kind,
                     e.want.status, out_tdata[31:0], out_tdata[63:32], out_tuser[2:0],
                     out_tuser[4:3]);
        end
      end
    end
    if (rx_stall == 0 && hold_req && !hold_done) begin
      rx_stall = RX_HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (rx_stall == 0 && !steady && $urandom_range(0, 3) == 0) begin
      rx_stall = idle_len();
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no item moved for %0d cycles, %0d results pending",
               idle_cycles, expected_patches.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/rrp_pkg.sv
rtl/rrp_ctrl.sv
rtl/rrp_dpath.sv
rtl/riscv_relocation_patcher_core.sv
tb/sv/riscv_relocation_patcher_core_test.sv
